// ----- rtl/vcfb_pkg.sv -----
// Shared types, codes and helpers for the voxel cube frame buffer.
// No dependencies; the top, front and back files import this package.
package vcfb_pkg;

    // Default frame geometry
    localparam int MAX_X_DEF = 8;
    localparam int MAX_Y_DEF = 8;
    localparam int MAX_Z_DEF = 8;

    // Configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_DEPTH  = 2'd1;
    localparam logic [1:0] REG_LAYERS = 2'd2;
    localparam logic [3:0] SIZE_RST   = 4'd8;

    // Command codes
    localparam logic [2:0] ACT_SET    = 3'd0;
    localparam logic [2:0] ACT_CLR    = 3'd1;
    localparam logic [2:0] ACT_READ   = 3'd2;
    localparam logic [2:0] ACT_XLAT   = 3'd3;
    localparam logic [2:0] ACT_CLRALL = 3'd4;
    localparam logic [2:0] ACT_UPDATE = 3'd5;
    localparam logic [2:0] ACT_SCAN   = 3'd6;
    localparam logic [2:0] ACT_NONE   = 3'd7;

    // Result kinds
    localparam logic [1:0] KIND_BIT = 2'd0;
    localparam logic [1:0] KIND_ROW = 2'd1;
    localparam logic [1:0] KIND_SEL = 2'd2;

    // Classified command handed from front to back
    typedef struct packed {
        logic [2:0] op;
        logic [4:0] x;
        logic [4:0] y;
        logic [4:0] z;
        logic       coord_ok;
    } t_cmd;

    // One result word
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
    } t_res;

    // Clamped active sizes, 1 up to the frame geometry (15 at most)
    typedef struct packed {
        logic [4:0] w;
        logic [4:0] h;
        logic [4:0] n;
    } t_size;

    // Clamp a size register to 1..mx
    function automatic logic [4:0] clamp_size(logic [3:0] v, logic [4:0] mx);
        logic [4:0] r;
        begin
            r = {1'b0, v};
            if (v == 4'd0) begin
                r = 5'd1;
            end else if ({1'b0, v} > mx) begin
                r = mx;
            end
            return r;
        end
    endfunction

endpackage

// ----- rtl/voxel_cube_frame_buffer.sv -----
// Voxel cube frame buffer: a work frame and a display frame of MAX_Y*MAX_Z
// rows, each kept in a one-port-write, one-port-read memory and walked by a
// sequencer one row per cycle in translate, clear all and update sweeps;
// a scan reads a row and puts it out in separate steps and can stall on the
// result side. After reset a clearing pass over all rows zeroes both frames,
// with full held high. Out-of-range set, clear and read voxel commands skip
// the memory; a read of one returns zero. A command queue lets new words in
// while the sequencer runs, and a result queue holds words until popped.
// Depends on vcfb_pkg, vcfb_fifo, vcfb_front and vcfb_back.
module voxel_cube_frame_buffer #(
    parameter int MAX_X = vcfb_pkg::MAX_X_DEF,
    parameter int MAX_Y = vcfb_pkg::MAX_Y_DEF,
    parameter int MAX_Z = vcfb_pkg::MAX_Z_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [2:0]                    i_action,
    input  logic [4:0]                    i_x,
    input  logic [4:0]                    i_y,
    input  logic [4:0]                    i_z,
    output logic                          empty,
    input  logic                          pop,
    output logic [1:0]                    o_kind,
    output logic [7:0]                    o_value,
    output logic                          o_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vcfb_pkg::APB_AW-1:0]   paddr,
    input  logic [vcfb_pkg::APB_DW-1:0]   pwdata,
    output logic [vcfb_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import vcfb_pkg::*;

    logic [3:0] r_width, r_depth, r_layers;
    t_size      w_size;
    t_cmd       w_cmd_in, w_cmd_out;
    t_res       w_res_in, w_res_out;
    logic       w_q_push, w_q_full, w_q_empty, w_q_pop;
    logic       w_r_push, w_r_full, w_init;
    logic       w_wr;

    // Configuration registers
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIZE_RST;
            r_depth  <= SIZE_RST;
            r_layers <= SIZE_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_WIDTH:  r_width  <= pwdata[3:0];
                REG_DEPTH:  r_depth  <= pwdata[3:0];
                REG_LAYERS: r_layers <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = APB_DW'(r_width);
            REG_DEPTH:  prdata = APB_DW'(r_depth);
            REG_LAYERS: prdata = APB_DW'(r_layers);
            default:    prdata = '0;
        endcase
    end

    // Clamp sizes to the frame geometry
    assign w_size.w = clamp_size(r_width, 5'(MAX_X));
    assign w_size.h = clamp_size(r_depth, 5'(MAX_Y));
    assign w_size.n = clamp_size(r_layers, 5'(MAX_Z));

    vcfb_front u_front (
        .i_push   (push),
        .o_full   (full),
        .i_action (i_action),
        .i_x      (i_x),
        .i_y      (i_y),
        .i_z      (i_z),
        .i_size   (w_size),
        .i_q_full (w_q_full),
        .i_init   (w_init),
        .o_q_push (w_q_push),
        .o_cmd    (w_cmd_in)
    );

    vcfb_fifo #(.W($bits(t_cmd)), .DEPTH(2)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_push),
        .i_wdata (w_cmd_in),
        .o_full  (w_q_full),
        .i_rd    (w_q_pop),
        .o_rdata (w_cmd_out),
        .o_empty (w_q_empty)
    );

    vcfb_back #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_size      (w_size),
        .i_cmd       (w_cmd_out),
        .i_cmd_empty (w_q_empty),
        .o_cmd_pop   (w_q_pop),
        .i_res_full  (w_r_full),
        .o_res_push  (w_r_push),
        .o_res       (w_res_in),
        .o_init      (w_init)
    );

    vcfb_fifo #(.W($bits(t_res)), .DEPTH(4)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_r_push),
        .i_wdata (w_res_in),
        .o_full  (w_r_full),
        .i_rd    (pop),
        .o_rdata (w_res_out),
        .o_empty (empty)
    );

    assign o_kind  = w_res_out.kind;
    assign o_value = w_res_out.value;
    assign o_last  = w_res_out.last;

endmodule

// ----- rtl/vcfb_fifo.sv -----
// Small register queue used for commands and for results.
// Depends on nothing but its parameters.
module vcfb_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  logic [W-1:0] i_wdata,
    output logic         o_full,
    input  logic         i_rd,
    output logic [W-1:0] o_rdata,
    output logic         o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_wr, w_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;

    // Advance pointers and count
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_wr) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (w_rd) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store word
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

// ----- rtl/vcfb_front.sv -----
// Front end: takes input words, checks coordinates against the active size
// and queues classified commands. Depends on vcfb_pkg.
module vcfb_front (
    input  logic             i_push,
    output logic             o_full,
    input  logic [2:0]       i_action,
    input  logic [4:0]       i_x,
    input  logic [4:0]       i_y,
    input  logic [4:0]       i_z,
    input  vcfb_pkg::t_size  i_size,
    input  logic             i_q_full,
    input  logic             i_init,
    output logic             o_q_push,
    output vcfb_pkg::t_cmd   o_cmd
);
    import vcfb_pkg::*;

    logic w_inside;

    // Coordinate is inside when non-negative and below the active size
    assign w_inside = !i_x[4] && !i_y[4] && !i_z[4] &&
                      ({1'b0, i_x[3:0]} < i_size.w) &&
                      ({1'b0, i_y[3:0]} < i_size.h) &&
                      ({1'b0, i_z[3:0]} < i_size.n);

    // Hold off input during the clearing pass; drop the unused action
    assign o_full   = i_q_full || i_init;
    assign o_q_push = i_push && !o_full && (i_action != ACT_NONE);

    assign o_cmd.op       = i_action;
    assign o_cmd.x        = i_x;
    assign o_cmd.y        = i_y;
    assign o_cmd.z        = i_z;
    assign o_cmd.coord_ok = w_inside;

endmodule

// ----- rtl/vcfb_back.sv -----
// Back end: frame memories and the sequencer that runs voxel, translate,
// clear, update and scan commands. Depends on vcfb_pkg.
module vcfb_back #(
    parameter int MAX_X = vcfb_pkg::MAX_X_DEF,
    parameter int MAX_Y = vcfb_pkg::MAX_Y_DEF,
    parameter int MAX_Z = vcfb_pkg::MAX_Z_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vcfb_pkg::t_size  i_size,
    input  vcfb_pkg::t_cmd   i_cmd,
    input  logic             i_cmd_empty,
    output logic             o_cmd_pop,
    input  logic             i_res_full,
    output logic             o_res_push,
    output vcfb_pkg::t_res   o_res,
    output logic             o_init
);
    import vcfb_pkg::*;

    localparam int RW   = MAX_X;
    localparam int ROWS = MAX_Y * MAX_Z;
    localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int KW   = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
    localparam int JW   = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;

    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_VOX      = 4'd2;
    localparam logic [3:0] S_XLAT     = 4'd3;
    localparam logic [3:0] S_CLR      = 4'd4;
    localparam logic [3:0] S_COPY     = 4'd5;
    localparam logic [3:0] S_SCAN_RD  = 4'd6;
    localparam logic [3:0] S_SCAN_PUT = 4'd7;
    localparam logic [3:0] S_SEL      = 4'd8;

    logic [RW-1:0] r_wmem [ROWS];
    logic [RW-1:0] r_dmem [ROWS];
    logic [RW-1:0] r_wrd, r_drd;

    logic [3:0]    r_state, n_state;
    logic [AW-1:0] r_a, n_a;
    logic [KW-1:0] r_k, n_k;
    logic [JW-1:0] r_j, n_j;
    logic          r_desc, n_desc;
    logic [2:0]    r_layer, n_layer;
    logic [2:0]    r_scan, n_scan;
    t_cmd          r_cmd, n_cmd;
    logic          r_p_vld, n_p_vld;
    logic [AW-1:0] r_p_addr, n_p_addr;
    logic          r_p_ok, n_p_ok;
    logic          r_p_copy, n_p_copy;

    logic [AW-1:0] w_raddr, w_waddr, w_draddr, w_dwaddr;
    logic [RW-1:0] w_wdata, w_ddata, w_mask, w_bit;
    logic          w_we, w_de;
    logic signed [6:0] w_sk, w_sj;
    logic          w_src_ok;
    logic [9:0]    w_off;
    logic [4:0]    w_nxt_layer;
    logic [15:0]   w_row16;

    function automatic logic [AW-1:0] row_addr(logic [KW-1:0] k, logic [JW-1:0] j);
        return AW'(9'(k) * 9'(MAX_Y) + 9'(j));
    endfunction

    // Shift one row along x with zero fill
    function automatic logic [RW-1:0] shift_row(logic [RW-1:0] r, logic [4:0] d,
                                                logic [4:0] w, logic [RW-1:0] m);
        logic [4:0]    mag;
        logic [RW-1:0] q;
        begin
            mag = d[4] ? (~d + 5'd1) : d;
            if (d == 5'd0) begin
                q = r;
            end else if (mag >= w) begin
                q = '0;
            end else if (!d[4]) begin
                q = (r << mag) & m;
            end else begin
                q = (r & m) >> mag;
            end
            return q;
        end
    endfunction

    // Active width mask
    always_comb begin
        for (int i = 0; i < RW; i++) begin
            w_mask[i] = (5'(i) < i_size.w);
        end
    end

    assign w_bit   = RW'(1) << r_cmd.x[3:0];
    assign w_sk    = $signed(7'(r_k)) - 7'($signed(r_cmd.z));
    assign w_sj    = $signed(7'(r_j)) - 7'($signed(r_cmd.y));
    assign w_src_ok = !w_sk[6] && (w_sk < $signed(7'(i_size.n))) &&
                      !w_sj[6] && (w_sj < $signed(7'(i_size.h)));
    assign w_off   = 10'($signed(i_cmd.z)) * 10'(MAX_Y) + 10'($signed(i_cmd.y));
    assign w_nxt_layer = 5'(r_layer) + 5'd1;
    assign w_row16 = 16'(r_drd & w_mask);
    assign o_init  = (r_state == S_INIT);

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_a      = r_a;
        n_k      = r_k;
        n_j      = r_j;
        n_desc   = r_desc;
        n_layer  = r_layer;
        n_scan   = r_scan;
        n_cmd    = r_cmd;
        n_p_vld  = 1'b0;
        n_p_addr = r_p_addr;
        n_p_ok   = r_p_ok;
        n_p_copy = r_p_copy;
        w_raddr  = '0;
        w_draddr = '0;
        w_we     = 1'b0;
        w_waddr  = '0;
        w_wdata  = '0;
        w_de     = 1'b0;
        w_dwaddr = '0;
        w_ddata  = '0;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;

        // Finish the write of the previous sweep step
        if (r_p_vld) begin
            if (r_p_copy) begin
                w_de     = 1'b1;
                w_dwaddr = r_p_addr;
                w_ddata  = r_wrd;
            end else begin
                w_we    = 1'b1;
                w_waddr = r_p_addr;
                w_wdata = r_p_ok ? shift_row(r_wrd, r_cmd.x, i_size.w, w_mask) : '0;
            end
        end

        case (r_state)
            S_INIT: begin
                w_we     = 1'b1;
                w_waddr  = r_a;
                w_de     = 1'b1;
                w_dwaddr = r_a;
                if (r_a == AW'(ROWS - 1)) begin
                    n_a     = '0;
                    n_state = S_IDLE;
                end else begin
                    n_a = r_a + 1'b1;
                end
            end
            S_IDLE: begin
                if (!r_p_vld && !i_cmd_empty) begin
                    case (i_cmd.op)
                        ACT_SET, ACT_CLR: begin
                            o_cmd_pop = 1'b1;
                            n_cmd     = i_cmd;
                            if (i_cmd.coord_ok) begin
                                w_raddr = row_addr(KW'(i_cmd.z[3:0]), JW'(i_cmd.y[3:0]));
                                n_state = S_VOX;
                            end
                        end
                        ACT_READ: begin
                            if (!i_res_full) begin
                                o_cmd_pop = 1'b1;
                                n_cmd     = i_cmd;
                                if (i_cmd.coord_ok) begin
                                    w_raddr = row_addr(KW'(i_cmd.z[3:0]),
                                                       JW'(i_cmd.y[3:0]));
                                    n_state = S_VOX;
                                end else begin
                                    o_res_push = 1'b1;
                                    o_res      = '{kind: KIND_BIT, value: 8'd0, last: 1'b1};
                                end
                            end
                        end
                        ACT_XLAT: begin
                            o_cmd_pop = 1'b1;
                            n_cmd     = i_cmd;
                            // Walk downward when sources lie below destinations
                            n_desc    = !w_off[9] && (w_off != 10'd0);
                            if (!w_off[9] && (w_off != 10'd0)) begin
                                n_k = KW'(i_size.n - 5'd1);
                                n_j = JW'(i_size.h - 5'd1);
                            end else begin
                                n_k = '0;
                                n_j = '0;
                            end
                            n_state = S_XLAT;
                        end
                        ACT_CLRALL: begin
                            o_cmd_pop = 1'b1;
                            n_a       = '0;
                            n_state   = S_CLR;
                        end
                        ACT_UPDATE: begin
                            o_cmd_pop = 1'b1;
                            n_a       = '0;
                            n_state   = S_COPY;
                        end
                        ACT_SCAN: begin
                            o_cmd_pop = 1'b1;
                            n_layer   = ({2'b0, r_scan} < i_size.n) ? r_scan : 3'd0;
                            n_j       = '0;
                            n_state   = S_SCAN_RD;
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_VOX: begin
                case (r_cmd.op)
                    ACT_SET: begin
                        w_we    = 1'b1;
                        w_waddr = row_addr(KW'(r_cmd.z[3:0]), JW'(r_cmd.y[3:0]));
                        w_wdata = r_wrd | w_bit;
                    end
                    ACT_CLR: begin
                        w_we    = 1'b1;
                        w_waddr = row_addr(KW'(r_cmd.z[3:0]), JW'(r_cmd.y[3:0]));
                        w_wdata = r_wrd & ~w_bit;
                    end
                    default: begin
                        o_res_push = 1'b1;
                        o_res      = '{kind: KIND_BIT,
                                       value: {7'd0, |(r_wrd & w_bit)},
                                       last: 1'b1};
                    end
                endcase
                n_state = S_IDLE;
            end
            S_XLAT: begin
                if (w_src_ok) begin
                    w_raddr = row_addr(KW'(w_sk), JW'(w_sj));
                end
                n_p_vld  = 1'b1;
                n_p_addr = row_addr(r_k, r_j);
                n_p_ok   = w_src_ok;
                n_p_copy = 1'b0;
                if (r_desc) begin
                    if (r_j == '0) begin
                        n_j = JW'(i_size.h - 5'd1);
                        if (r_k == '0) begin
                            n_state = S_IDLE;
                        end else begin
                            n_k = r_k - 1'b1;
                        end
                    end else begin
                        n_j = r_j - 1'b1;
                    end
                end else begin
                    if (5'(r_j) == i_size.h - 5'd1) begin
                        n_j = '0;
                        if (5'(r_k) == i_size.n - 5'd1) begin
                            n_state = S_IDLE;
                        end else begin
                            n_k = r_k + 1'b1;
                        end
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            S_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_a;
                w_wdata = '0;
                if (r_a == AW'(ROWS - 1)) begin
                    n_a     = '0;
                    n_state = S_IDLE;
                end else begin
                    n_a = r_a + 1'b1;
                end
            end
            S_COPY: begin
                w_raddr  = r_a;
                n_p_vld  = 1'b1;
                n_p_addr = r_a;
                n_p_copy = 1'b1;
                if (r_a == AW'(ROWS - 1)) begin
                    n_a     = '0;
                    n_state = S_IDLE;
                end else begin
                    n_a = r_a + 1'b1;
                end
            end
            S_SCAN_RD: begin
                if (!i_res_full) begin
                    w_draddr = row_addr(KW'(r_layer), r_j);
                    n_state  = S_SCAN_PUT;
                end
            end
            S_SCAN_PUT: begin
                o_res_push = 1'b1;
                o_res      = '{kind: KIND_ROW, value: w_row16[7:0], last: 1'b0};
                if (5'(r_j) == i_size.h - 5'd1) begin
                    n_state = S_SEL;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_SEL: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    o_res      = '{kind: KIND_SEL, value: 8'd1 << r_layer, last: 1'b1};
                    n_scan     = (w_nxt_layer == i_size.n) ? 3'd0 : w_nxt_layer[2:0];
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_a     <= '0;
            r_scan  <= '0;
            r_p_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_a     <= n_a;
            r_scan  <= n_scan;
            r_p_vld <= n_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_j      <= n_j;
        r_desc   <= n_desc;
        r_layer  <= n_layer;
        r_cmd    <= n_cmd;
        r_p_addr <= n_p_addr;
        r_p_ok   <= n_p_ok;
        r_p_copy <= n_p_copy;
    end

    // Work frame memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_wmem[w_waddr] <= w_wdata;
        end
        r_wrd <= r_wmem[w_raddr];
    end

    // Display frame memory
    always_ff @(posedge i_clk) begin
        if (w_de) begin
            r_dmem[w_dwaddr] <= w_ddata;
        end
        r_drd <= r_dmem[w_draddr];
    end

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into a full queue");

    a_pend_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_vld |-> ($past(r_state) == S_XLAT || $past(r_state) == S_COPY))
        else $error("pending row write without a sweep");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == S_IDLE && !r_p_vld))
        else $error("command taken while busy");

endmodule
